// ===== rtl/core/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, table constants and stage types for the NTC ADC-to-temperature
// converter. Holds the breakpoint table and per-segment slope, span and
// reciprocal constants.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // Field and datapath widths
    localparam int ADC_W     = 12;
    localparam int TEMP_W    = 12;
    localparam int NPTS      = 12;
    localparam int SEG_W     = 4;
    localparam int DELTA_W   = 11;  // code minus segment floor, below 1432
    localparam int DT_W      = 9;   // temperature drop across a segment, up to 390
    localparam int DEN_W     = 11;  // segment code span, up to 1432
    localparam int PROD_W    = 19;  // dt * delta, up to 429300
    localparam int RCP_W     = 14;
    localparam int RCP_SHIFT = 19;
    localparam int MUL_W     = PROD_W + RCP_W;
    localparam int QUO_W     = 9;   // quotient never above the segment drop
    localparam int REM_W     = 12;  // remainder before correction, below 2 * span
    localparam int QMUL_W    = QUO_W + DEN_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_HIGH = 2'd1;

    localparam logic [ADC_W-1:0] FAULT_LOW_RST  = 12'd50;
    localparam logic [ADC_W-1:0] FAULT_HIGH_RST = 12'd4050;

    // Breakpoints: falling codes, rising temperatures
    localparam int PT_CODE [NPTS] = '{4096, 3509, 2945, 1513, 1126, 823,
                                      596, 432, 314, 230, 171, 0};
    localparam int PT_TEMP [NPTS] = '{-500, -250, -100, 200, 300, 400,
                                      500, 600, 700, 800, 900, 1290};

    // floor(2^RCP_SHIFT / span) for the segment ending at each point
    localparam int SEG_RCP [NPTS] = '{
        0,
        (1 << RCP_SHIFT) / (4096 - 3509),
        (1 << RCP_SHIFT) / (3509 - 2945),
        (1 << RCP_SHIFT) / (2945 - 1513),
        (1 << RCP_SHIFT) / (1513 - 1126),
        (1 << RCP_SHIFT) / (1126 - 823),
        (1 << RCP_SHIFT) / (823 - 596),
        (1 << RCP_SHIFT) / (596 - 432),
        (1 << RCP_SHIFT) / (432 - 314),
        (1 << RCP_SHIFT) / (314 - 230),
        (1 << RCP_SHIFT) / (230 - 171),
        (1 << RCP_SHIFT) / (171 - 0)
    };

    typedef logic [SEG_W-1:0] seg_t;

    // Item leaving the segment-select stage
    typedef struct packed {
        logic                valid;
        logic                fault;
        seg_t                seg;
        logic [DELTA_W-1:0]  delta;
    } seg_item_t;

    // Item leaving the interpolation pipe
    typedef struct packed {
        logic                valid;
        logic                fault;
        logic [TEMP_W-1:0]   temp;
    } res_item_t;

    function automatic logic seg_ok(input seg_t s);
        return (s != '0) && (s < SEG_W'(NPTS));
    endfunction

    function automatic logic [ADC_W-1:0] pt_code(input seg_t s);
        logic [ADC_W-1:0] r;
        r = '0;
        if (seg_ok(s))
        begin
            r = ADC_W'(PT_CODE[s]);
        end
        return r;
    endfunction

    function automatic logic signed [TEMP_W-1:0] pt_temp(input seg_t s);
        logic signed [TEMP_W-1:0] r;
        r = '0;
        if (seg_ok(s))
        begin
            r = TEMP_W'(PT_TEMP[s]);
        end
        return r;
    endfunction

    function automatic logic [DT_W-1:0] seg_dt(input seg_t s);
        logic [DT_W-1:0] r;
        r = '0;
        if (seg_ok(s))
        begin
            r = DT_W'(PT_TEMP[s] - PT_TEMP[s - 1'b1]);
        end
        return r;
    endfunction

    function automatic logic [DEN_W-1:0] seg_den(input seg_t s);
        logic [DEN_W-1:0] r;
        r = '0;
        if (seg_ok(s))
        begin
            r = DEN_W'(PT_CODE[s - 1'b1] - PT_CODE[s]);
        end
        return r;
    endfunction

    function automatic logic [RCP_W-1:0] seg_rcp(input seg_t s);
        logic [RCP_W-1:0] r;
        r = '0;
        if (seg_ok(s))
        begin
            r = RCP_W'(SEG_RCP[s]);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/ntc_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// Thermistor ADC code to temperature in tenths of a degree, by piecewise
// linear interpolation over a fixed 12-point table, with a fault window.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy never rises. Five register stages:
// segment select, slope multiply, reciprocal multiply, remainder, correction.
// Reset clears all valid bits and loads the fault limits with 50 and 4050.
// Results cannot be stalled; done is a single-cycle strobe.
module ntc_adc_to_temperature (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] adc_code,
    output logic        done,
    output logic [11:0] temp_tenths,
    output logic        fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import ntc_pkg::*;

    logic [ADC_W-1:0] fault_low_reg, fault_low_next;
    logic [ADC_W-1:0] fault_high_reg, fault_high_next;
    logic             accept;
    seg_item_t        seg_item;
    res_item_t        res_item;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Fault limit registers
    always_comb
    begin
        fault_low_next  = fault_low_reg;
        fault_high_next = fault_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FAULT_LOW:  fault_low_next  = cfg_data;
                CFG_FAULT_HIGH: fault_high_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_low_reg  <= FAULT_LOW_RST;
            fault_high_reg <= FAULT_HIGH_RST;
        end
        else
        begin
            fault_low_reg  <= fault_low_next;
            fault_high_reg <= fault_high_next;
        end
    end

    ntc_seg u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .adc_code   (adc_code),
        .fault_low  (fault_low_reg),
        .fault_high (fault_high_reg),
        .seg_item   (seg_item)
    );

    ntc_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg_item (seg_item),
        .res_item (res_item)
    );

    assign done        = res_item.valid;
    assign fault       = res_item.fault;
    assign temp_tenths = res_item.temp;

endmodule

// ===== rtl/core/ntc_seg.sv =====
// ----------------------------------------------------------------------------
// ntc_seg
// First pipeline stage: fault window check, parallel breakpoint compares,
// segment pick and offset of the code above the segment floor.
// ----------------------------------------------------------------------------
module ntc_seg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [11:0]               adc_code,
    input  logic [11:0]               fault_low,
    input  logic [11:0]               fault_high,
    output ntc_pkg::seg_item_t        seg_item
);
    import ntc_pkg::*;

    logic                valid_reg, valid_next;
    logic                fault_reg, fault_next;
    seg_t                seg_reg, seg_next;
    logic [DELTA_W-1:0]  delta_reg, delta_next;
    logic [ADC_W-1:0]    diff;

    // Smallest point index whose code is not above the input
    always_comb
    begin
        seg_next = SEG_W'(NPTS - 1);
        for (int k = NPTS - 1; k >= 1; k--)
        begin
            if (adc_code >= pt_code(SEG_W'(k)))
            begin
                seg_next = SEG_W'(k);
            end
        end
        diff       = adc_code - pt_code(seg_next);
        delta_next = diff[DELTA_W-1:0];
        fault_next = (adc_code > fault_high) || (adc_code < fault_low);
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fault_reg <= fault_next;
        seg_reg   <= seg_next;
        delta_reg <= delta_next;
    end

    assign seg_item.valid = valid_reg;
    assign seg_item.fault = fault_reg;
    assign seg_item.seg   = seg_reg;
    assign seg_item.delta = delta_reg;

endmodule

// ===== rtl/core/ntc_interp.sv =====
// ----------------------------------------------------------------------------
// ntc_interp
// Interpolation pipe: slope product, reciprocal multiply, remainder check and
// one-step quotient correction, then subtraction from the point temperature, or zero for a fault item.
// ----------------------------------------------------------------------------
module ntc_interp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ntc_pkg::seg_item_t        seg_item,
    output ntc_pkg::res_item_t        res_item
);
    import ntc_pkg::*;

    // Stage B: product of segment drop and code offset
    logic                b_valid_reg, b_valid_next;
    logic                b_fault_reg;
    seg_t                b_seg_reg;
    logic [PROD_W-1:0]   b_prod_reg, b_prod_next;

    // Stage C: quotient estimate by reciprocal
    logic                c_valid_reg, c_valid_next;
    logic                c_fault_reg;
    seg_t                c_seg_reg;
    logic [PROD_W-1:0]   c_prod_reg;
    logic [QUO_W-1:0]    c_quo_reg, c_quo_next;
    logic [MUL_W-1:0]    c_scaled;

    // Stage D: remainder of the estimate
    logic                d_valid_reg, d_valid_next;
    logic                d_fault_reg;
    seg_t                d_seg_reg;
    logic [QUO_W-1:0]    d_quo_reg;
    logic [REM_W-1:0]    d_rem_reg, d_rem_next;
    logic [QMUL_W-1:0]   d_back;
    logic [PROD_W-1:0]   d_diff;

    // Stage E: corrected quotient and final temperature
    logic                e_valid_reg, e_valid_next;
    logic                e_fault_reg;
    logic [TEMP_W-1:0]   e_temp_reg, e_temp_next;
    logic [QUO_W-1:0]    e_quo;

    always_comb
    begin
        b_valid_next = seg_item.valid;
        b_prod_next  = PROD_W'(seg_dt(seg_item.seg)) * PROD_W'(seg_item.delta);

        c_valid_next = b_valid_reg;
        c_scaled     = MUL_W'(b_prod_reg) * MUL_W'(seg_rcp(b_seg_reg));
        c_quo_next   = QUO_W'(c_scaled >> RCP_SHIFT);

        d_valid_next = c_valid_reg;
        d_back       = QMUL_W'(c_quo_reg) * QMUL_W'(seg_den(c_seg_reg));
        d_diff       = c_prod_reg - PROD_W'(d_back);
        d_rem_next   = d_diff[REM_W-1:0];

        e_valid_next = d_valid_reg;
        e_quo        = d_quo_reg;
        if (d_rem_reg >= REM_W'(seg_den(d_seg_reg)))
        begin
            e_quo = d_quo_reg + 1'b1;
        end
        if (d_fault_reg)
        begin
            e_temp_next = '0;
        end
        else
        begin
            e_temp_next = pt_temp(d_seg_reg) - $signed(TEMP_W'(e_quo));
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            e_valid_reg <= e_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        b_fault_reg <= seg_item.fault;
        b_seg_reg   <= seg_item.seg;
        b_prod_reg  <= b_prod_next;

        c_fault_reg <= b_fault_reg;
        c_seg_reg   <= b_seg_reg;
        c_prod_reg  <= b_prod_reg;
        c_quo_reg   <= c_quo_next;

        d_fault_reg <= c_fault_reg;
        d_seg_reg   <= c_seg_reg;
        d_quo_reg   <= c_quo_reg;
        d_rem_reg   <= d_rem_next;

        e_fault_reg <= d_fault_reg;
        e_temp_reg  <= e_temp_next;
    end

    assign res_item.valid = e_valid_reg;
    assign res_item.fault = e_fault_reg;
    assign res_item.temp  = e_temp_reg;

endmodule

// ===== rtl/core/ntc_chk.sv =====
// ----------------------------------------------------------------------------
// ntc_chk
// Port-level checks for the converter: fixed latency, range of results and
// zero temperature on fault. Bound to the top level.
// ----------------------------------------------------------------------------
module ntc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [11:0] temp_tenths,
    input logic        fault
);

    // Every accepted item yields a done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("accepted item produced no result");

    // No strobe without a matching accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without a matching item");

    // Fault results carry zero temperature
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fault) |-> (temp_tenths == 12'd0))
        else $error("fault result with nonzero temperature");

    // Good results stay within the table span
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !fault) |->
            ($signed(temp_tenths) >= -12'sd500 && $signed(temp_tenths) <= 12'sd1290))
        else $error("temperature outside table span");

endmodule

bind ntc_adc_to_temperature ntc_chk u_ntc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .temp_tenths (temp_tenths),
    .fault       (fault)
);
